@@ src/afd_pkg.sv @@
`default_nettype none
package afd_pkg;

  localparam logic [7:0]  START_BYTE    = 8'h7E;
  localparam logic [7:0]  CHECK_BASE    = 8'hFF;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_CMD    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CHECK  = 3'd5;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BADSUM  = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;

  typedef struct packed {
    logic       has;
    logic [7:0] data;
    logic       is_cmd;
    logic       eof;
    logic [1:0] status;
  } afd_res_t;

endpackage
`default_nettype wire

@@ src/afd_in_reg.sv @@
`default_nettype none
module afd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  output logic            in_stall,
  input  wire logic       consume,
  output logic            byte_valid_r,
  output logic [7:0]      byte_r
);
  import afd_pkg::*;

  logic load;

  // take a new beat whenever the slot is empty or drains this cycle
  assign in_stall = byte_valid_r && !consume;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (load) begin
      byte_valid_r <= 1'b1;
    end else if (consume) begin
      byte_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
    end
  end

endmodule
`default_nettype wire

@@ src/afd_core.sv @@
`default_nettype none
module afd_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire logic [7:0]  byte_in,
  input  wire logic [15:0] max_len,
  output afd_pkg::afd_res_t res
);
  import afd_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] full_len;
  logic [15:0] left_dec;

  assign full_len = {len_hi_r, byte_in};
  assign left_dec = left_r - 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    sum_nxt    = sum_r;
    res        = '0;
    unique case (phase_r)
      PH_LEN_HI: begin
        len_hi_nxt = byte_in;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sum_nxt = 8'd0;
        if (full_len > max_len) begin
          res.has    = 1'b1;
          res.eof    = 1'b1;
          res.status = ST_TOOLONG;
          phase_nxt  = PH_HUNT;
        end else begin
          left_nxt  = full_len;
          phase_nxt = (full_len == 16'd0) ? PH_CHECK : PH_CMD;
        end
      end
      PH_CMD: begin
        sum_nxt    = byte_in;
        left_nxt   = left_dec;
        phase_nxt  = (left_dec == 16'd0) ? PH_CHECK : PH_DATA;
        res.has    = 1'b1;
        res.data   = byte_in;
        res.is_cmd = 1'b1;
      end
      PH_DATA: begin
        sum_nxt  = sum_r + byte_in;
        left_nxt = left_dec;
        if (left_dec == 16'd0) begin
          phase_nxt = PH_CHECK;
        end
        res.has  = 1'b1;
        res.data = byte_in;
      end
      PH_CHECK: begin
        res.has    = 1'b1;
        res.eof    = 1'b1;
        res.status = (byte_in == (CHECK_BASE - sum_r)) ? ST_GOOD : ST_BADSUM;
        phase_nxt  = PH_HUNT;
      end
      default: begin
        // hunting, and any unused code: wait for the start byte
        phase_nxt = (byte_in == START_BYTE) ? PH_LEN_HI : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      len_hi_r <= 8'd0;
      left_r   <= 16'd0;
      sum_r    <= 8'd0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      len_hi_r <= len_hi_nxt;
      left_r   <= left_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/afd_out_reg.sv @@
`default_nettype none
module afd_out_reg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  afd_pkg::afd_res_t res,
  output logic              free,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_byte,
  output logic              out_is_command,
  output logic              out_end_of_frame,
  output logic [1:0]        out_frame_status
);
  import afd_pkg::*;

  logic     valid_r;
  afd_res_t res_r;

  assign free             = !valid_r || !out_stall;
  assign out_valid        = valid_r;
  assign out_byte         = res_r.data;
  assign out_is_command   = res_r.is_cmd;
  assign out_end_of_frame = res_r.eof;
  assign out_frame_status = res_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

@@ src/api_frame_deframer.sv @@
// API-mode frame receiver with an 8-bit checksum.
// Input channel: one received byte per beat on in_byte (in_valid / in_stall).
// The block hunts for the start byte 0x7E, reads a big-endian 16-bit length,
// then passes the command byte (out_is_command set) and each data byte out
// as they arrive. The checksum byte closes the frame with an end beat
// (out_end_of_frame set, out_byte zero, out_frame_status good or bad sum).
// A length above cfg max closes at once with status too-long on the low
// length byte. Start, hunted and accepted length bytes give no output beat.
// Configuration: cfg_wr_en / cfg_wr_data write the maximum frame length
// (reset 1024); write it only while the block is idle.
// Path: an accepted byte passes the input register, then the result
// register, before it shows on the output.
// Throughput: one byte per cycle while the result register can take its result.
// Stall: while out_stall holds a result, one more byte is taken into the
// input register; bytes that give no output keep draining regardless.
// Reset (rst_n low, synchronous) drops any held beats and returns to hunting.
`default_nettype none
module api_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_is_command,
  output logic             out_end_of_frame,
  output logic [1:0]       out_frame_status
);
  import afd_pkg::*;

  logic [15:0] max_len_r;
  logic        byte_valid_r;
  logic [7:0]  byte_r;
  logic        consume;
  logic        out_free;
  afd_res_t    res;

  // advance the held byte when its result has a place, or it has no result
  assign consume = byte_valid_r && (out_free || !res.has);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  afd_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_byte      (in_byte),
    .in_stall     (in_stall),
    .consume      (consume),
    .byte_valid_r (byte_valid_r),
    .byte_r       (byte_r)
  );

  afd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (consume),
    .byte_in (byte_r),
    .max_len (max_len_r),
    .res     (res)
  );

  afd_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (consume && res.has),
    .res              (res),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_is_command   (out_is_command),
    .out_end_of_frame (out_end_of_frame),
    .out_frame_status (out_frame_status)
  );

endmodule
`default_nettype wire
